FILE: rtl/core/multichannel_dma_address_engine_unit_defines.svh
// Assertion macros for the DMA address engine.
// Included by the top level; no other dependencies.
`ifndef MULTICHANNEL_DMA_ADDRESS_ENGINE_UNIT_DEFINES_SVH
`define MULTICHANNEL_DMA_ADDRESS_ENGINE_UNIT_DEFINES_SVH

// same-cycle implication
`define MDAE_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mdae: same-cycle check failed");

// next-cycle implication
`define MDAE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mdae: next-cycle check failed");

`endif

FILE: rtl/core/mdae_pkg.sv
// Shared types, codes and sizes for the DMA address engine.
// No dependencies.
package mdae_pkg;

  localparam int CHANNELS = 4;
  localparam int IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int COUNT_W  = 17;
  localparam int FLAGS_W  = 16;

  localparam logic [1:0] CMD_SETUP   = 2'd0;
  localparam logic [1:0] CMD_TRIGGER = 2'd1;
  localparam logic [1:0] CMD_ISSUE   = 2'd2;
  localparam logic [1:0] CMD_CANCEL  = 2'd3;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_BEAT = 2'd1;
  localparam logic [1:0] KIND_BUSY = 2'd2;

  localparam int FLAG_DMODE_LO  = 5;
  localparam int FLAG_SMODE_LO  = 7;
  localparam int FLAG_REPEAT    = 9;
  localparam int FLAG_WIDE      = 10;
  localparam int FLAG_TIMING_LO = 12;
  localparam int FLAG_ENABLE    = 15;

  localparam logic [1:0] MODE_INC    = 2'd0;
  localparam logic [1:0] MODE_DEC    = 2'd1;
  localparam logic [1:0] MODE_FIXED  = 2'd2;
  localparam logic [1:0] MODE_RELOAD = 2'd3;

  typedef struct packed {
    logic [1:0]  command;
    logic [1:0]  channel;
    logic [31:0] source_address;
    logic [31:0] dest_address;
    logic [31:0] control_word;
    logic [1:0]  start_timing;
  } cmd_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  beat_channel;
    logic [31:0] read_address;
    logic [31:0] write_address;
    logic        wide_beat;
    logic        last_beat;
  } rsp_item_t;

  typedef struct packed {
    logic load;
    logic exec;
  } dp_ctrl_t;

  typedef struct packed {
    logic pending_any;
  } dp_status_t;

endpackage

FILE: rtl/core/mdae_ctrl.sv
// Handshake controller: capture and execute sequencing, response valid.
// Depends on mdae_pkg.
module mdae_ctrl import mdae_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     cmd_valid,
  output logic     cmd_stall,
  output logic     rsp_valid,
  input  logic     rsp_stall,
  output dp_ctrl_t ctrl
);

  localparam logic STATE_IDLE = 1'b0;
  localparam logic STATE_EXEC = 1'b1;

  logic state, state_next;
  logic rsp_valid_next;

  always_comb begin
    state_next = state;
    ctrl       = '0;
    cmd_stall  = 1'b1;
    unique case (state)
      STATE_IDLE: begin
        cmd_stall = 1'b0;
        if (cmd_valid) begin
          ctrl.load  = 1'b1;
          state_next = STATE_EXEC;
        end
      end
      STATE_EXEC: begin
        if (!rsp_valid || !rsp_stall) begin
          ctrl.exec  = 1'b1;
          state_next = STATE_IDLE;
        end
      end
      default: state_next = STATE_IDLE;
    endcase
    rsp_valid_next = ctrl.exec | (rsp_valid & rsp_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= STATE_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

endmodule

FILE: rtl/core/mdae_dp.sv
// Datapath: channel register file, pending mask, trigger and beat logic,
// transaction and response registers. Depends on mdae_pkg.
module mdae_dp import mdae_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  dp_ctrl_t   ctrl,
  input  cmd_item_t  cmd,
  output rsp_item_t  rsp,
  output dp_status_t status
);

  cmd_item_t item;

  logic [31:0]        current_source [CHANNELS];
  logic [31:0]        current_dest   [CHANNELS];
  logic [COUNT_W-1:0] remaining_count[CHANNELS];
  logic [FLAGS_W-1:0] channel_flags  [CHANNELS];
  logic [31:0]        reload_dest    [CHANNELS];
  logic [COUNT_W-1:0] reload_count   [CHANNELS];
  logic [CHANNELS-1:0] register_enable;
  logic [CHANNELS-1:0] pending_mask;

  logic [31:0]        current_source_next [CHANNELS];
  logic [31:0]        current_dest_next   [CHANNELS];
  logic [COUNT_W-1:0] remaining_count_next[CHANNELS];
  logic [FLAGS_W-1:0] channel_flags_next  [CHANNELS];
  logic [31:0]        reload_dest_next    [CHANNELS];
  logic [COUNT_W-1:0] reload_count_next   [CHANNELS];
  logic [CHANNELS-1:0] register_enable_next;
  logic [CHANNELS-1:0] pending_mask_next;
  rsp_item_t           rsp_next;

  logic [IDX_W-1:0]   pick;
  logic [FLAGS_W-1:0] pick_flags;
  logic [31:0]        step_size;
  logic [1:0]         smode;
  logic [COUNT_W-1:0] count_dec;
  logic               do_trigger;
  logic [1:0]         timing;
  logic               ch_in_range;

  function automatic logic [31:0] step_addr(input logic [31:0] a, input logic [1:0] mode,
                                            input logic [31:0] size);
    logic [31:0] r;
    r = a;
    case (mode)
      MODE_INC, MODE_RELOAD: r = a + size;
      MODE_DEC:              r = a - size;
      default:               r = a;
    endcase
    return r;
  endfunction

  assign status.pending_any = |pending_mask;
  assign ch_in_range        = (32'(item.channel) < 32'(CHANNELS));

  always_comb begin
    pick = '0;
    for (int c = CHANNELS - 1; c >= 0; c--) begin
      if (pending_mask[c]) pick = IDX_W'(c);
    end
  end

  assign pick_flags = channel_flags[pick];
  assign step_size  = pick_flags[FLAG_WIDE] ? 32'd4 : 32'd2;
  assign smode      = (pick_flags[FLAG_SMODE_LO +: 2] == MODE_RELOAD) ? MODE_FIXED
                                                                      : pick_flags[FLAG_SMODE_LO +: 2];
  assign count_dec  = remaining_count[pick] - COUNT_W'(1);

  always_comb begin
    current_source_next  = current_source;
    current_dest_next    = current_dest;
    remaining_count_next = remaining_count;
    channel_flags_next   = channel_flags;
    reload_dest_next     = reload_dest;
    reload_count_next    = reload_count;
    register_enable_next = register_enable;
    pending_mask_next    = pending_mask;
    rsp_next             = '0;
    do_trigger           = 1'b0;
    timing               = item.start_timing;

    if (item.command == CMD_ISSUE) begin
      if (status.pending_any) begin
        rsp_next.kind          = KIND_BEAT;
        rsp_next.beat_channel  = 2'(pick);
        rsp_next.read_address  = current_source[pick];
        rsp_next.write_address = current_dest[pick];
        rsp_next.wide_beat     = pick_flags[FLAG_WIDE];
        current_dest_next[pick] = step_addr(current_dest[pick],
                                            pick_flags[FLAG_DMODE_LO +: 2], step_size);
        current_source_next[pick] = step_addr(current_source[pick], smode, step_size);
        remaining_count_next[pick] = count_dec;
        if (count_dec == '0) begin
          rsp_next.last_beat      = 1'b1;
          pending_mask_next[pick] = 1'b0;
          if (pick_flags[FLAG_REPEAT]) begin
            remaining_count_next[pick] = reload_count[pick];
            if (pick_flags[FLAG_DMODE_LO +: 2] == MODE_RELOAD)
              current_dest_next[pick] = reload_dest[pick];
          end else begin
            channel_flags_next[pick][FLAG_ENABLE] = 1'b0;
          end
        end
      end
    end else if (status.pending_any) begin
      rsp_next.kind = KIND_BUSY;
    end else if (item.command == CMD_TRIGGER) begin
      do_trigger = 1'b1;
    end else if (ch_in_range) begin
      if (item.command == CMD_SETUP) begin
        current_source_next [item.channel[IDX_W-1:0]] = item.source_address;
        current_dest_next   [item.channel[IDX_W-1:0]] = item.dest_address;
        reload_dest_next    [item.channel[IDX_W-1:0]] = item.dest_address;
        remaining_count_next[item.channel[IDX_W-1:0]] = item.control_word[COUNT_W-1:0];
        reload_count_next   [item.channel[IDX_W-1:0]] = item.control_word[COUNT_W-1:0];
        channel_flags_next  [item.channel[IDX_W-1:0]] = item.control_word[31:16];
        register_enable_next[item.channel[IDX_W-1:0]] = item.control_word[31];
        do_trigger = 1'b1;
        timing     = 2'd0;
      end else begin
        register_enable_next[item.channel[IDX_W-1:0]] = 1'b0;
      end
    end

    if (do_trigger) begin
      for (int c = 0; c < CHANNELS; c++) begin
        if (!register_enable_next[c]) channel_flags_next[c][FLAG_ENABLE] = 1'b0;
        if (channel_flags_next[c][FLAG_ENABLE] &&
            channel_flags_next[c][FLAG_TIMING_LO +: 2] == timing) begin
          if (remaining_count_next[c] != '0) begin
            pending_mask_next[c] = 1'b1;
          end else if (channel_flags_next[c][FLAG_REPEAT]) begin
            remaining_count_next[c] = reload_count_next[c];
            if (channel_flags_next[c][FLAG_DMODE_LO +: 2] == MODE_RELOAD)
              current_dest_next[c] = reload_dest_next[c];
          end else begin
            channel_flags_next[c][FLAG_ENABLE] = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) item <= cmd;
    if (ctrl.exec) begin
      rsp             <= rsp_next;
      current_source  <= current_source_next;
      current_dest    <= current_dest_next;
      remaining_count <= remaining_count_next;
      reload_dest     <= reload_dest_next;
      reload_count    <= reload_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CHANNELS; c++) channel_flags[c] <= '0;
      register_enable <= '0;
      pending_mask    <= '0;
    end else if (ctrl.exec) begin
      channel_flags   <= channel_flags_next;
      register_enable <= register_enable_next;
      pending_mask    <= pending_mask_next;
    end
  end

endmodule

FILE: rtl/core/multichannel_dma_address_engine_unit.sv
// Top level of the four-channel DMA address engine.
// Depends on mdae_pkg, mdae_ctrl, mdae_dp and the defines header.

// Each transaction has a capture step, which takes in the command, and an execute
// step, which runs it against the channel register file and loads the response
// register; no new command is taken until the execute step is done. The execute step waits
// while an earlier response is still stalled. Setup, trigger and cancel are
// answered busy while any channel has a run pending; issue commands drain the
// lowest pending channel one beat at a time. No clearing pass after reset.
`include "multichannel_dma_address_engine_unit_defines.svh"

module multichannel_dma_address_engine_unit import mdae_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  output logic      cmd_stall,
  input  cmd_item_t cmd,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output rsp_item_t rsp
);

  dp_ctrl_t   ctrl;
  dp_status_t status;

  mdae_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .ctrl      (ctrl)
  );

  mdae_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .cmd    (cmd),
    .rsp    (rsp),
    .status (status)
  );

  `MDAE_ASSERT_NEXT(a_one_at_a_time, clk, rst, cmd_valid && !cmd_stall, cmd_stall)
  `MDAE_ASSERT_NOW(a_no_beat_zero, clk, rst, rsp_valid && rsp.kind != KIND_BEAT,
    rsp.read_address == '0 && rsp.write_address == '0 && !rsp.last_beat)
  `MDAE_ASSERT_NOW(a_busy_pending, clk, rst, rsp_valid && rsp.kind == KIND_BUSY,
    status.pending_any)

endmodule

FILE: sim/tb.sv
// Testbench for the four-channel DMA address engine: directed and random command
// streams, every response checked field by field against a local beat predictor.
// Depends on mdae_pkg and multichannel_dma_address_engine_unit.
module tb import mdae_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD   = 400;
  localparam int ITEMS       = 450;

  logic      clk;
  logic      rst;
  logic      cmd_valid = 1'b0;
  logic      cmd_stall;
  cmd_item_t cmd = '0;
  logic      rsp_valid;
  logic      rsp_stall = 1'b0;
  rsp_item_t rsp;

  multichannel_dma_address_engine_unit dut (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  // predicted channel register file
  logic [31:0]        ch_src   [CHANNELS];
  logic [31:0]        ch_dst   [CHANNELS];
  logic [31:0]        ch_rdst  [CHANNELS];
  logic [COUNT_W-1:0] ch_cnt   [CHANNELS];
  logic [COUNT_W-1:0] ch_rcnt  [CHANNELS];
  logic [FLAGS_W-1:0] ch_flags [CHANNELS];
  logic               ch_ren   [CHANNELS];
  logic [CHANNELS-1:0] ch_pend;

  cmd_item_t cmd_pend[$];
  rsp_item_t rsp_due[$];
  int n_sent = 0, n_acc = 0, n_loaded = 0, n_rsp = 0;
  int errors = 0, cycles = 0;
  int send_gap = 0, rsp_hold = 0;
  logic cmd_taken = 1'b0, rsp_taken = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] next_addr(logic [31:0] a, logic [1:0] mode,
                                            logic [31:0] size);
    if (mode == MODE_INC || mode == MODE_RELOAD) return a + size;
    if (mode == MODE_DEC) return a - size;
    return a;
  endfunction

  function automatic void finish_run(int c);
    if (ch_flags[c][FLAG_REPEAT]) begin
      ch_cnt[c] = ch_rcnt[c];
      if (ch_flags[c][FLAG_DMODE_LO +: 2] == MODE_RELOAD) ch_dst[c] = ch_rdst[c];
    end else begin
      ch_flags[c][FLAG_ENABLE] = 1'b0;
    end
  endfunction

  function automatic void fire_trigger(logic [1:0] timing);
    for (int c = 0; c < CHANNELS; c++) begin
      if (!ch_ren[c]) ch_flags[c][FLAG_ENABLE] = 1'b0;
      if (ch_flags[c][FLAG_ENABLE] && ch_flags[c][FLAG_TIMING_LO +: 2] == timing) begin
        if (ch_cnt[c] != '0) ch_pend[c] = 1'b1;
        else finish_run(c);
      end
    end
  endfunction

  function automatic rsp_item_t engine_step(cmd_item_t c);
    rsp_item_t r;
    int pick;
    logic [31:0] size;
    logic [FLAGS_W-1:0] f;
    logic [1:0] sm;
    r = '0;
    if (c.command == CMD_ISSUE) begin
      if (ch_pend != '0) begin
        pick = 0;
        for (int i = CHANNELS - 1; i >= 0; i--) if (ch_pend[i]) pick = i;
        f = ch_flags[pick];
        size = f[FLAG_WIDE] ? 32'd4 : 32'd2;
        sm = f[FLAG_SMODE_LO +: 2];
        r.kind = KIND_BEAT;
        r.beat_channel = IDX_W'(pick);
        r.read_address = ch_src[pick];
        r.write_address = ch_dst[pick];
        r.wide_beat = f[FLAG_WIDE];
        ch_dst[pick] = next_addr(ch_dst[pick], f[FLAG_DMODE_LO +: 2], size);
        ch_src[pick] = next_addr(ch_src[pick], (sm == MODE_RELOAD) ? MODE_FIXED : sm, size);
        ch_cnt[pick] = ch_cnt[pick] - COUNT_W'(1);
        if (ch_cnt[pick] == '0) begin
          r.last_beat = 1'b1;
          ch_pend[pick] = 1'b0;
          finish_run(pick);
        end
      end
    end else if (ch_pend != '0) begin
      r.kind = KIND_BUSY;
    end else if (c.command == CMD_TRIGGER) begin
      fire_trigger(c.start_timing);
    end else if (int'(c.channel) < CHANNELS) begin
      if (c.command == CMD_SETUP) begin
        ch_src[c.channel] = c.source_address;
        ch_dst[c.channel] = c.dest_address;
        ch_rdst[c.channel] = c.dest_address;
        ch_cnt[c.channel] = c.control_word[COUNT_W-1:0];
        ch_rcnt[c.channel] = c.control_word[COUNT_W-1:0];
        ch_flags[c.channel] = c.control_word[31:16];
        ch_ren[c.channel] = c.control_word[31];
        fire_trigger(2'd0);
      end else begin
        ch_ren[c.channel] = 1'b0;
      end
    end
    return r;
  endfunction

  function automatic int field_bad(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  function automatic int pause(bit quiet);
    return quiet ? 0 : $urandom_range(0, 16);
  endfunction

  // transaction capture, prediction and response check
  always @(posedge clk) begin
    rsp_item_t want;
    cmd_taken <= !rst && cmd_valid && !cmd_stall;
    rsp_taken <= !rst && rsp_valid && !rsp_stall;
    if (!rst) begin
      if (rsp_valid && !rsp_stall) begin
        n_rsp++;
        if (rsp_due.size() == 0) begin
          $display("%0t: response with none expected, actual %h", $time, rsp);
          errors++;
        end else begin
          want = rsp_due.pop_front();
          errors += field_bad("kind", 32'(want.kind), 32'(rsp.kind))
                  + field_bad("beat_channel", 32'(want.beat_channel), 32'(rsp.beat_channel))
                  + field_bad("read_address", want.read_address, rsp.read_address)
                  + field_bad("write_address", want.write_address, rsp.write_address)
                  + field_bad("wide_beat", 32'(want.wide_beat), 32'(rsp.wide_beat))
                  + field_bad("last_beat", 32'(want.last_beat), 32'(rsp.last_beat));
        end
      end
      if (cmd_valid && !cmd_stall) begin
        rsp_due.push_back(engine_step(cmd));
        n_acc++;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // command driver
  always @(negedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (cmd_valid && !cmd_taken) begin
    end else if (send_gap > 0) begin
      cmd_valid <= 1'b0;
      send_gap--;
    end else if (cmd_pend.size() > 0) begin
      cmd <= cmd_pend.pop_front();
      cmd_valid <= 1'b1;
      send_gap = pause((n_loaded / 40) % 4 == 1);
      n_loaded++;
    end else begin
      cmd_valid <= 1'b0;
    end
  end

  // response receiver, with one long hold to back up the command side
  always @(negedge clk) begin
    if (rsp_taken) rsp_hold = (n_rsp == 150) ? LONG_HOLD : pause((n_rsp / 50) % 4 == 2);
    if (!rst && rsp_hold > 0) begin
      rsp_stall <= 1'b1;
      rsp_hold--;
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  function automatic cmd_item_t make_cmd(logic [1:0] op, logic [1:0] ch, logic [31:0] src,
                                         logic [31:0] dst, logic [31:0] ctl, logic [1:0] tim);
    cmd_item_t c;
    c.command = op;
    c.channel = ch;
    c.source_address = src;
    c.dest_address = dst;
    c.control_word = ctl;
    c.start_timing = tim;
    return c;
  endfunction

  function automatic logic [31:0] ctl_of(int count, logic [1:0] dm, logic [1:0] sm, bit rep,
                                         bit wide, logic [1:0] tim, bit en);
    logic [31:0] w;
    w = '0;
    w[COUNT_W-1:0] = count[COUNT_W-1:0];
    w[16 + FLAG_DMODE_LO +: 2] = dm;
    w[16 + FLAG_SMODE_LO +: 2] = sm;
    w[16 + FLAG_REPEAT] = rep;
    w[16 + FLAG_WIDE] = wide;
    w[16 + FLAG_TIMING_LO +: 2] = tim;
    w[16 + FLAG_ENABLE] = en;
    return w;
  endfunction

  function automatic logic [31:0] rand_addr();
    case ($urandom_range(0, 5))
      0: return 32'hFFFF_FFF0 + $urandom_range(0, 15);
      1: return $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  task automatic push_cmd(cmd_item_t c);
    cmd_pend.push_back(c);
    n_sent++;
  endtask

  task automatic push_op(logic [1:0] op, logic [1:0] ch, logic [31:0] ctl, logic [1:0] tim);
    push_cmd(make_cmd(op, ch, 32'h0000_1000 * ch + 32'h10, 32'h0000_8000 + ch, ctl, tim));
  endtask

  // junk command; setups keep the enable bit low so they stay inert
  task automatic push_noise();
    cmd_item_t c;
    c = make_cmd(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), $urandom, $urandom,
                 $urandom, 2'($urandom_range(0, 3)));
    c.control_word[16 + FLAG_ENABLE] = 1'b0;
    if (c.command == CMD_ISSUE) c.command = CMD_SETUP;
    push_cmd(c);
  endtask

  // wait until the predictor is current, then issue the beats still owed, sometimes one extra
  task automatic drain_runs();
    int beats;
    wait (n_acc == n_sent);
    beats = 0;
    for (int i = 0; i < CHANNELS; i++) if (ch_pend[i]) beats += int'(ch_cnt[i]);
    if ($urandom_range(0, 5) == 0) beats++;
    repeat (beats)
      push_cmd(make_cmd(CMD_ISSUE, 2'($urandom_range(0, 3)), $urandom, $urandom, $urandom,
                        2'($urandom_range(0, 3))));
  endtask

  initial begin
    logic [31:0] ctl;
    logic [1:0] last_tim;
    int count;
    rst = 1'b1;
    for (int i = 0; i < CHANNELS; i++) begin
      ch_src[i] = '0; ch_dst[i] = '0; ch_rdst[i] = '0;
      ch_cnt[i] = '0; ch_rcnt[i] = '0; ch_flags[i] = '0; ch_ren[i] = 1'b0;
    end
    ch_pend = '0;
    repeat (12) @(posedge clk);
    @(negedge clk) rst = 1'b0;

    // idle issue, busy rejects, address wrap
    push_op(CMD_ISSUE, 2'd0, '0, 2'd0);
    push_cmd(make_cmd(CMD_SETUP, 2'd0, 32'hFFFF_FFFE, 32'h0000_0002,
                      ctl_of(2, MODE_DEC, MODE_INC, 0, 0, 2'd0, 1), 2'd0));
    push_op(CMD_SETUP, 2'd1, ctl_of(3, MODE_INC, MODE_INC, 0, 0, 2'd0, 1), 2'd0);
    push_op(CMD_TRIGGER, 2'd0, '0, 2'd0);
    push_op(CMD_CANCEL, 2'd0, '0, 2'd0);
    push_op(CMD_ISSUE, 2'd0, '0, 2'd0);
    push_op(CMD_ISSUE, 2'd0, '0, 2'd0);
    // repeat with destination reload, retrigger, then cancel takes effect at trigger
    push_op(CMD_SETUP, 2'd1, ctl_of(1, MODE_RELOAD, MODE_FIXED, 1, 1, 2'd0, 1), 2'd0);
    push_op(CMD_ISSUE, 2'd0, '0, 2'd0);
    push_op(CMD_TRIGGER, 2'd0, '0, 2'd0);
    push_op(CMD_ISSUE, 2'd0, '0, 2'd0);
    push_op(CMD_CANCEL, 2'd1, '0, 2'd0);
    push_op(CMD_TRIGGER, 2'd0, '0, 2'd0);
    push_op(CMD_ISSUE, 2'd0, '0, 2'd0);
    // zero count ends at once
    push_op(CMD_SETUP, 2'd2, ctl_of(0, MODE_INC, MODE_INC, 0, 0, 2'd0, 1), 2'd0);
    // full count on a deferred timing, cancelled before it ever runs
    push_cmd(make_cmd(CMD_SETUP, 2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                      ctl_of(int'(17'h1FFFF), MODE_RELOAD, MODE_RELOAD, 1, 1, 2'd3, 1), 2'd3));
    push_op(CMD_CANCEL, 2'd3, '0, 2'd3);
    push_op(CMD_TRIGGER, 2'd0, '0, 2'd3);
    // fixed addressing on a timed trigger
    push_op(CMD_SETUP, 2'd2, ctl_of(2, MODE_FIXED, MODE_RELOAD, 0, 1, 2'd2, 1), 2'd0);
    push_op(CMD_TRIGGER, 2'd0, '0, 2'd2);
    push_op(CMD_ISSUE, 2'd0, '0, 2'd0);
    push_op(CMD_ISSUE, 2'd0, '0, 2'd0);
    // two channels pending: lower index first
    push_op(CMD_SETUP, 2'd1, ctl_of(2, MODE_DEC, MODE_DEC, 0, 1, 2'd1, 1), 2'd0);
    push_op(CMD_SETUP, 2'd0, ctl_of(1, MODE_INC, MODE_FIXED, 0, 0, 2'd1, 1), 2'd0);
    push_op(CMD_TRIGGER, 2'd0, '0, 2'd1);
    drain_runs();

    last_tim = 2'd0;
    while (n_sent < ITEMS) begin
      repeat ($urandom_range(1, 3)) begin
        case ($urandom_range(0, 9))
          0: count = 0;
          1: count = $urandom_range(7, 40);
          default: count = $urandom_range(1, 6);
        endcase
        ctl = $urandom;
        ctl[COUNT_W-1:0] = count[COUNT_W-1:0];
        ctl[16 + FLAG_ENABLE] = ($urandom_range(0, 7) != 0);
        if ($urandom_range(0, 1) == 0) ctl[16 + FLAG_TIMING_LO +: 2] = 2'd0;
        last_tim = ctl[16 + FLAG_TIMING_LO +: 2];
        push_cmd(make_cmd(CMD_SETUP, 2'($urandom_range(0, 3)), rand_addr(), rand_addr(), ctl,
                          2'($urandom_range(0, 3))));
        if ($urandom_range(0, 3) == 0) push_noise();
        drain_runs();
      end
      if ($urandom_range(0, 4) == 0) push_op(CMD_CANCEL, 2'($urandom_range(0, 3)), '0, 2'd0);
      push_op(CMD_TRIGGER, 2'd0, '0,
              ($urandom_range(0, 9) < 6) ? last_tim : 2'($urandom_range(0, 3)));
      if ($urandom_range(0, 5) == 0) push_noise();
      drain_runs();
    end

    wait (n_acc == n_sent && rsp_due.size() == 0);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
